// ----- sv/djpu_pkg.sv -----
// Package: shared types and constants for the damped Jacobi point update block
package djpu_pkg;

  localparam int unsigned ValW   = 32;
  localparam int unsigned OmegaW = 17;
  localparam int unsigned HW     = 17;
  localparam int unsigned SumW   = 48;
  localparam int unsigned SqW    = 64;
  localparam logic [OmegaW-1:0] OmegaReset = 17'd65536;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_JACOBI = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // One queued request between the front and the back part
  typedef struct packed {
    logic [1:0]        mode;
    logic [ValW-1:0]   u_value;
    logic [ValW-1:0]   residual_value;
    logic [ValW-1:0]   diag_value;
    logic [HW-1:0]     h_volume;
    logic              zero_diag;
    logic [OmegaW-1:0] omega;
  } item_t;

  typedef struct packed {
    logic [ValW-1:0] new_value;
    logic [31:0]     solution_max_norm;
    logic [SumW-1:0] solution_h_norm;
    logic [31:0]     update_max_norm;
    logic [SumW-1:0] update_h_norm;
    logic [31:0]     residual_max_norm;
    logic [31:0]     residual_euclid_norm;
    logic [31:0]     update_count;
    logic            zero_diag_flag;
  } result_t;

endpackage

// ----- sv/djpu_if.sv -----
// Interfaces: request, result and configuration channels
interface djpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] u_value;
  logic [31:0] residual_value;
  logic [31:0] diag_value;
  logic [16:0] h_volume;
  modport source (output valid, mode, u_value, residual_value, diag_value, h_volume,
                  input ready);
  modport sink (input valid, mode, u_value, residual_value, diag_value, h_volume,
                output ready);
endinterface

interface djpu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_value;
  logic [31:0] solution_max_norm;
  logic [47:0] solution_h_norm;
  logic [31:0] update_max_norm;
  logic [47:0] update_h_norm;
  logic [31:0] residual_max_norm;
  logic [31:0] residual_euclid_norm;
  logic [31:0] update_count;
  logic        zero_diag_flag;
  modport source (output valid, new_value, solution_max_norm, solution_h_norm,
                  update_max_norm, update_h_norm, residual_max_norm,
                  residual_euclid_norm, update_count, zero_diag_flag, input ready);
  modport sink (input valid, new_value, solution_max_norm, solution_h_norm,
                update_max_norm, update_h_norm, residual_max_norm,
                residual_euclid_norm, update_count, zero_diag_flag, output ready);
endinterface

interface djpu_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- sv/damped_jacobi_point_update_with_norms.sv -----
// Top level: damped Jacobi point update with running norms
// In the back part, a Jacobi update with a non-zero diagonal goes through a 49-step
// restoring divider for omega*residual/diag and then a square root stage (a fold step, a
// weighting step and 32 root bits) on the residual sum of squares; other items, and a zero
// diagonal, skip the divider. A queue (two entries by default) sits between the accepting
// front and the back, and a result register holds the answer until it is taken; the back
// takes no new request while a result waits. Omega is sampled when an item is accepted.
module damped_jacobi_point_update_with_norms #(
  parameter int unsigned QueueDepth = 2
) (
  input logic        clk,
  input logic        rst,
  djpu_in_if.sink    in_req,
  djpu_out_if.source out_res,
  djpu_cfg_if.sink   cfg
);
  logic [djpu_pkg::OmegaW-1:0] omega;
  logic                        q_valid;
  logic                        q_pop;
  djpu_pkg::item_t             q_item;

  // Hold the relaxation factor
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      omega <= djpu_pkg::OmegaReset;
    end else if (cfg.valid) begin
      omega <= cfg.data;
    end
  end

  djpu_front #(.Depth(QueueDepth)) u_front (
    .clk(clk), .rst(rst), .req(in_req), .omega(omega),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  djpu_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .res(out_res)
  );
endmodule

// ----- sv/djpu_front.sv -----
// Front part: accept requests, classify them and queue them for the back part
module djpu_front #(
  parameter int unsigned Depth = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  djpu_in_if.sink                     req,
  input  logic [djpu_pkg::OmegaW-1:0] omega,
  output logic                        q_valid,
  input  logic                        q_pop,
  output djpu_pkg::item_t             q_item
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  djpu_pkg::item_t       slots [Depth];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [PtrW:0]         fill;
  logic                  push;
  djpu_pkg::item_t       in_item;

  assign req.ready = (fill != (PtrW+1)'(Depth));
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != '0);
  assign q_item    = slots[rd_ptr];

  // Classify: tag zero diagonal and take omega at acceptance
  always_comb begin
    in_item.mode           = req.mode;
    in_item.u_value        = req.u_value;
    in_item.residual_value = req.residual_value;
    in_item.diag_value     = req.diag_value;
    in_item.h_volume       = req.h_volume;
    in_item.zero_diag      = (req.diag_value == '0);
    in_item.omega          = omega;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Advance the pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) fill <= (PtrW+1)'(Depth))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> (fill == $past(fill) + 1'b1))
    else $error("fill count missed a push");
endmodule

// ----- sv/djpu_back.sv -----
// Back part: divider, statistics folding, square root and result register
module djpu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_pop,
  input  djpu_pkg::item_t q_item,
  djpu_out_if.source      res
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MUL  = 8'b00000010,
    S_DIV  = 8'b00000100,
    S_UPD  = 8'b00001000,
    S_WGT  = 8'b00010000,
    S_FOLD = 8'b00100000,
    S_SQRT = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state;
  djpu_pkg::item_t it;

  // Statistics
  logic [31:0] sol_max, upd_max, res_max, step_count;
  logic [47:0] sol_sum, upd_sum;
  logic [63:0] sq_sum;

  // Working registers
  logic [48:0] num_mag;     // |omega*r|, below 2^48
  logic        q_neg;
  logic [48:0] quot;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic [31:0] upd;
  logic [31:0] newv;
  logic [32:0] mag_a, mag_b;  // magnitudes to weight
  logic [49:0] wterm_a, wterm_b;
  logic [63:0] sq;
  logic [31:0] root;
  logic [63:0] sq_work;

  logic [32:0] r_mag, u_mag, d_mag;
  logic [33:0] rem_sh;
  logic [31:0] cand;
  logic [63:0] cand_sq;
  logic signed [32:0] sum_s;
  logic signed [49:0] q_s;

  always_comb begin
    r_mag  = it.residual_value[31] ? 33'(-{1'b1, it.residual_value})
                                   : {1'b0, it.residual_value};
    u_mag  = it.u_value[31] ? 33'(-{1'b1, it.u_value}) : {1'b0, it.u_value};
    d_mag  = it.diag_value[31] ? 33'(-{1'b1, it.diag_value}) : {1'b0, it.diag_value};
    rem_sh = {rem, num_mag[48]};
    cand   = root | (32'd1 << cnt[4:0]);
    cand_sq = 64'(cand) * 64'(cand);
    q_s    = q_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    sum_s  = $signed({it.u_value[31], it.u_value}) + $signed({upd[31], upd});
  end

  assign q_pop = (state == S_IDLE) && q_valid && !res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res.valid  <= 1'b0;
      sol_max    <= '0;
      upd_max    <= '0;
      res_max    <= '0;
      step_count <= '0;
      sol_sum    <= '0;
      upd_sum    <= '0;
      sq_sum     <= '0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            it    <= q_item;
            state <= S_MUL;
          end
        end
        // Form the numerator magnitude and the quotient sign
        S_MUL: begin
          num_mag <= 49'({32'd0, it.omega} * {16'd0, r_mag});
          q_neg   <= it.residual_value[31] ^ it.diag_value[31];
          rem     <= '0;
          quot    <= '0;
          cnt     <= 6'd49;
          upd     <= '0;
          if (it.mode == djpu_pkg::MODE_JACOBI && !it.zero_diag) begin
            state <= S_DIV;
          end else begin
            state <= S_UPD;
          end
        end
        // Restoring division, one quotient bit a cycle
        S_DIV: begin
          if (rem_sh >= {1'b0, d_mag}) begin
            rem  <= 33'(rem_sh - {1'b0, d_mag});
            quot <= {quot[47:0], 1'b1};
          end else begin
            rem  <= rem_sh[32:0];
            quot <= {quot[47:0], 1'b0};
          end
          num_mag <= {num_mag[47:0], 1'b0};
          cnt     <= cnt - 1'b1;
          if (cnt == 6'd1) state <= S_UPD;
        end
        // Saturate the update; the new value is saturated in S_WGT
        S_UPD: begin
          if (it.mode == djpu_pkg::MODE_JACOBI && !it.zero_diag) begin
            if (q_s > 50'sd2147483647) upd <= 32'h7FFFFFFF;
            else if (q_s < -50'sd2147483648) upd <= 32'h80000000;
            else upd <= q_s[31:0];
          end
          state <= S_WGT;
        end
        S_WGT: begin
          if (it.mode == djpu_pkg::MODE_JACOBI) begin
            if (sum_s > 33'sd2147483647) newv <= 32'h7FFFFFFF;
            else if (sum_s < -33'sd2147483648) newv <= 32'h80000000;
            else newv <= sum_s[31:0];
            mag_a <= upd[31] ? 33'(-{1'b1, upd}) : {1'b0, upd};
          end else begin
            newv  <= it.u_value;
            mag_a <= '0;
          end
          sq    <= 64'(r_mag) * 64'(r_mag);
          state <= S_FOLD;
        end
        // Form the new-value magnitude and the weighted update term
        S_FOLD: begin
          mag_b <= newv[31] ? 33'(-{1'b1, newv}) : {1'b0, newv};
          wterm_a <= 50'((67'(mag_a) * 67'(it.h_volume)) >> 16);
          state <= S_SQRT;
          cnt   <= 6'd33;
        end
        S_SQRT: begin
          if (cnt == 6'd33) begin
            wterm_b <= 50'((67'(mag_b) * 67'(it.h_volume)) >> 16);
            cnt <= 6'd32;
            case (it.mode)
              djpu_pkg::MODE_INIT, djpu_pkg::MODE_JACOBI: begin
                if (r_mag[31:0] > res_max) res_max <= r_mag[31:0];
                sq_work <= (64'(sq_sum + sq) < sq_sum) ? '1 : sq_sum + sq;
                sq_sum  <= (64'(sq_sum + sq) < sq_sum) ? '1 : sq_sum + sq;
                if (it.mode == djpu_pkg::MODE_JACOBI) begin
                  if (mag_a[31:0] > upd_max) upd_max <= mag_a[31:0];
                  if (step_count != '1) step_count <= step_count + 1'b1;
                end
              end
              djpu_pkg::MODE_CLEAR: begin
                sol_max <= '0; upd_max <= '0; res_max <= '0; step_count <= '0;
                sol_sum <= '0; upd_sum <= '0; sq_sum <= '0; sq_work <= '0;
              end
              default: sq_work <= sq_sum;
            endcase
            root <= '0;
          end else if (cnt == 6'd32) begin
            // Weighted sums, saturating at full scale
            if (it.mode == djpu_pkg::MODE_INIT || it.mode == djpu_pkg::MODE_JACOBI) begin
              if (mag_b[31:0] > sol_max && it.mode == djpu_pkg::MODE_JACOBI)
                sol_max <= mag_b[31:0];
              if (u_mag[31:0] > sol_max && it.mode == djpu_pkg::MODE_INIT)
                sol_max <= u_mag[31:0];
              if (it.mode == djpu_pkg::MODE_JACOBI) begin
                sol_sum <= (50'(sol_sum) + wterm_b > 50'hFFFFFFFFFFFF) ? '1
                         : 48'(50'(sol_sum) + wterm_b);
                upd_sum <= (50'(upd_sum) + wterm_a > 50'hFFFFFFFFFFFF) ? '1
                         : 48'(50'(upd_sum) + wterm_a);
              end else begin
                sol_sum <= (50'(sol_sum) + 50'((67'(u_mag) * 67'(it.h_volume)) >> 16)
                            > 50'hFFFFFFFFFFFF) ? '1
                         : 48'(50'(sol_sum) + 50'((67'(u_mag) * 67'(it.h_volume)) >> 16));
              end
            end
            cnt <= 6'd31;
          end else begin
            // Square root, one bit a cycle
            if (cand_sq <= sq_work) root <= cand;
            if (cnt == 6'd0) state <= S_OUT;
            else cnt <= cnt - 1'b1;
          end
        end
        S_OUT: begin
          if (!res.valid) begin
            res.valid                <= 1'b1;
            res.new_value            <= newv;
            res.solution_max_norm    <= sol_max;
            res.solution_h_norm      <= sol_sum;
            res.update_max_norm      <= upd_max;
            res.update_h_norm        <= upd_sum;
            res.residual_max_norm    <= res_max;
            res.residual_euclid_norm <= root;
            res.update_count         <= step_count;
            res.zero_diag_flag       <= (it.mode == djpu_pkg::MODE_JACOBI) && it.zero_diag;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !res.valid)
    else $error("pop while result waits");
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |=> res.valid)
    else $error("result dropped");
endmodule
